// ===== hw/rtl/fac_pkg.sv =====
`default_nettype none
package fac_pkg;

  localparam int NUM_INPUTS       = 64;
  localparam int NUM_COLUMNS      = 16;
  localparam int CELLS_PER_COLUMN = 16;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] REG_VIG_LOW  = 2'd0;
  localparam logic [1:0] REG_VIG_HIGH = 2'd1;
  localparam logic [1:0] REG_BIAS     = 2'd2;
  localparam logic [1:0] REG_RATE     = 2'd3;

  localparam logic [15:0] VIG_LOW_RST  = 16'd32768;
  localparam logic [15:0] VIG_HIGH_RST = 16'd45875;
  localparam logic [15:0] BIAS_RST     = 16'd6554;
  localparam logic [15:0] RATE_RST     = 16'd32768;

  localparam logic [16:0] EPS_Q16     = 17'd7;
  localparam logic [16:0] COMMIT_RATE = 17'd64881;

  // quotient request to the shared divider
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [47:0] den;
  } div_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fac_ram.sv =====
`default_nettype none
module fac_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/fac_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module fac_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fac_pkg::div_req_t req_i,
  output      logic             busy_o,
  output      logic [47:0]      quot_o
);
  logic [47:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [48:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[47]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = 6'd47;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[48]) begin
        rem_d = trial[47:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[46:0], quo_q[47]};
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

// ===== hw/rtl/fuzzy_art_column_learner.sv =====
`default_nettype none
// fuzzy art column learner with dual vigilance, q0.16 fixed point
//
// input channel: one word per accepted item; operation selects a weight
// write (weight_address, value) or an input element (value, last_element,
// learn_enable). a last element starts evaluation: every cell walks
// NUM_INPUTS elements through one min/add datapath, then the shared
// 48-step divider runs twice (match, activation), and a compare step
// follows. a column of CELLS_PER_COLUMN cells is then reduced and, when
// learning is enabled, up to TOP_K passes over the columns pick learners;
// each learner rewrites NUM_INPUTS weights, each by a read, multiply and
// write step.
// the input stall is high for the whole evaluation and result phase.
// output channel: NUM_COLUMNS result words in column order, last_result on
// the final one; a stalled result holds and the block waits for it.
// configuration writes take effect at once; the user makes them only while idle, the block does not check.
// reset clears the committed flags, counters and registers; the weight and
// input stores keep whatever they held and must be written before use.
module fuzzy_art_column_learner #(
  parameter int TOP_K = 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [13:0] weight_address_i,
  input  wire logic [15:0] value_i,
  input  wire logic        last_element_i,
  input  wire logic        learn_enable_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [3:0]  column_o,
  output      logic [3:0]  shown_cell_o,
  output      logic        has_learn_cell_o,
  output      logic [3:0]  learn_cell_o,
  output      logic        column_learned_o,
  output      logic [15:0] comparison_o,
  output      logic        last_result_o
);
  localparam int NUM_INPUTS       = fac_pkg::NUM_INPUTS;
  localparam int NUM_COLUMNS      = fac_pkg::NUM_COLUMNS;
  localparam int CELLS_PER_COLUMN = fac_pkg::CELLS_PER_COLUMN;
  localparam int NumCells   = NUM_COLUMNS * CELLS_PER_COLUMN;
  localparam int NumWeights = NumCells * NUM_INPUTS;
  localparam int IW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int CW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int DW = (CELLS_PER_COLUMN > 1) ? $clog2(CELLS_PER_COLUMN) : 1;
  localparam int NW = $clog2(NumCells + 1);
  localparam int LW = (NumCells > 1) ? $clog2(NumCells) : 1;
  localparam int WW = (NumWeights > 1) ? $clog2(NumWeights) : 1;
  localparam int KW = $clog2(TOP_K + 1);
  localparam int SW = 16 + $clog2(NUM_INPUTS + 1);
  localparam logic [IW:0] NInp = (IW + 1)'(NUM_INPUTS);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_INPUTS - 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SUM    = 13'b0000000000010,
    S_DIVM   = 13'b0000000000100,
    S_DIVA   = 13'b0000000001000,
    S_CMP    = 13'b0000000010000,
    S_COLEND = 13'b0000000100000,
    S_SELINI = 13'b0000001000000,
    S_SEL    = 13'b0000010000000,
    S_LRNCHK = 13'b0000100000000,
    S_LRNRD  = 13'b0001000000000,
    S_LRNMUL = 13'b0010000000000,
    S_LRNWR  = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] vig_low_q, vig_high_q, bias_q, rate_q;
  logic [IW:0] elem_cnt_q;
  logic        learn_q;
  logic [NumCells-1:0] committed_q;

  logic [15:0] comp_q [NUM_COLUMNS];
  logic [DW-1:0] shown_q [NUM_COLUMNS];
  logic [DW-1:0] lcell_q [NUM_COLUMNS];
  logic [NUM_COLUMNS-1:0] has_q, sel_q, work_zero_q;

  logic [CW-1:0] col_q;
  logic [DW-1:0] cell_q;
  logic [IW:0]   j_q;       // read pointer, runs past the last element for pipeline drain
  logic [SW-1:0] min_sum_q, tin_q, tw_q;
  logic          div_wait_q;
  logic [16:0]   match_q;
  logic [15:0]   act_q;
  logic [15:0]   best_low_q, best_high_q, best_all_q;
  logic [DW-1:0] win_high_q, win_all_q;
  logic          found_high_q;
  logic [KW-1:0] k_q;
  logic [15:0]   sel_best_q;
  logic [CW-1:0] sel_col_q;
  logic          sel_found_q;
  logic [15:0]   lw_q, lx_q;
  logic [33:0]   prod_q;
  logic          lrd_second_q;

  // stores
  logic [15:0] x_rdata, w_rdata;
  logic        x_we, w_we;
  logic [IW-1:0] x_waddr, x_raddr;
  logic [WW-1:0] w_waddr, w_raddr;
  logic [15:0]   w_wdata;

  fac_ram #(.Width(16), .Depth(NUM_INPUTS)) u_x_ram (
    .clk_i, .we_i(x_we), .waddr_i(x_waddr), .wdata_i(value_i),
    .raddr_i(x_raddr), .rdata_o(x_rdata)
  );
  fac_ram #(.Width(16), .Depth(NumWeights)) u_w_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  fac_pkg::div_req_t div_req;
  logic        div_busy;
  logic [47:0] div_quot;
  fac_div u_div (.clk_i, .rst_ni, .req_i(div_req), .busy_o(div_busy), .quot_o(div_quot));

  logic in_acc, out_acc;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;

  logic [LW-1:0] lcell_idx;
  logic [NW+CW+DW:0] cell_full;
  assign cell_full = (NW+CW+DW+1)'(col_q) * (NW+CW+DW+1)'(CELLS_PER_COLUMN)
                     + (NW+CW+DW+1)'(cell_q);
  logic [NW+CW+DW:0] lcell_full;
  assign lcell_full = (NW+CW+DW+1)'(col_q) * (NW+CW+DW+1)'(CELLS_PER_COLUMN)
                      + (NW+CW+DW+1)'(lcell_q[col_q]);
  assign lcell_idx = LW'(lcell_full);
  logic [LW-1:0] eval_idx;
  assign eval_idx = LW'(cell_full);

  logic [IW-1:0] jr;
  assign jr = j_q[IW-1:0];
  logic [IW-1:0] jw;   // element being written back during learning
  assign jw = jr;

  assign x_we    = in_acc && operation_i == fac_pkg::OP_SAMPLE && elem_cnt_q < NInp;
  assign x_waddr = elem_cnt_q[IW-1:0];
  assign x_raddr = jr;

  logic [WW+IW:0] w_base;
  assign w_base = (WW+IW+1)'((state_q == S_SUM) ? eval_idx : lcell_idx)
                  * (WW+IW+1)'(NUM_INPUTS) + (WW+IW+1)'(jr);
  assign w_raddr = WW'(w_base);

  logic wr_ok;
  assign wr_ok = {1'b0, weight_address_i} < 15'(NumWeights);
  logic lrn_wr;
  assign lrn_wr = (state_q == S_LRNWR);
  assign w_we    = lrn_wr || (in_acc && operation_i == fac_pkg::OP_WRITE && wr_ok);

  // learning product: the shared multiplier takes w then x
  logic        lcommitted;
  assign lcommitted = committed_q[lcell_idx];
  logic [16:0] rate_w, rate_x;
  assign rate_x = lcommitted ? {1'b0, rate_q} : fac_pkg::COMMIT_RATE;
  assign rate_w = 17'h10000 - rate_x;
  logic [33:0] mul_res;
  logic        mul_sel_x;
  assign mul_sel_x = (state_q == S_LRNWR);
  assign mul_res = mul_sel_x ? {18'd0, lx_q} * {17'd0, rate_x}
                             : {18'd0, lw_q} * {17'd0, rate_w};
  logic [34:0] lsum;
  assign lsum = {1'b0, prod_q} + {1'b0, mul_res} + 35'd32768;
  logic [15:0] new_w;
  assign new_w = (lcommitted && !(lx_q < lw_q)) ? lw_q : lsum[31:16];
  assign w_wdata = lrn_wr ? new_w : value_i;
  assign w_waddr = lrn_wr ? WW'((WW+IW+1)'(lcell_idx) * (WW+IW+1)'(NUM_INPUTS)
                                + (WW+IW+1)'(jw)) : WW'(weight_address_i);

  // divider requests
  logic [SW-1:0] tin_den;
  assign tin_den = (tin_q > SW'(fac_pkg::EPS_Q16)) ? tin_q : SW'(fac_pkg::EPS_Q16);
  logic [SW:0] act_den;
  assign act_den = {1'b0, tw_q} + (SW+1)'(bias_q);

  always_comb begin
    div_req = '0;
    if (state_q == S_SUM && j_q == NInp + 1'b1) begin
      div_req.start = 1'b1;
      div_req.num   = 48'({min_sum_q, 16'd0});
      div_req.den   = 48'(tin_den);
    end else if (state_q == S_DIVM && !div_wait_q && !div_busy) begin
      div_req.start = 1'b1;
      div_req.num   = 48'({min_sum_q, 16'd0});
      div_req.den   = 48'(act_den);
    end
  end

  logic [15:0] xm, wm;
  assign xm = x_rdata;
  assign wm = w_rdata;

  logic [15:0] cur_work;
  assign cur_work = work_zero_q[col_q] ? 16'd0 : comp_q[col_q];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && operation_i == fac_pkg::OP_SAMPLE && last_element_i)
                  state_d = S_SUM;
      S_SUM:    if (j_q == NInp + 1'b1) state_d = S_DIVM;
      S_DIVM:   if (!div_wait_q && !div_busy) state_d = S_DIVA;
      S_DIVA:   if (!div_wait_q && !div_busy) state_d = S_CMP;
      S_CMP:    state_d = (cell_q == DW'(CELLS_PER_COLUMN - 1)) ? S_COLEND : S_SUM;
      S_COLEND: state_d = (col_q == CW'(NUM_COLUMNS - 1)) ?
                          (learn_q ? S_SELINI : S_OUT) : S_SUM;
      S_SELINI: state_d = S_SEL;
      S_SEL:    if (col_q == CW'(NUM_COLUMNS - 1)) begin
                  if (!(sel_found_q || (cur_work > sel_best_q)) ||
                      k_q == KW'(TOP_K - 1))
                    state_d = S_LRNCHK;
                  else
                    state_d = S_SEL;
                end
      S_LRNCHK: if (sel_q[col_q] && has_q[col_q]) state_d = S_LRNRD;
                else if (col_q == CW'(NUM_COLUMNS - 1)) state_d = S_OUT;
      S_LRNRD:  if (lrd_second_q) state_d = S_LRNMUL;
      S_LRNMUL: state_d = S_LRNWR;
      S_LRNWR:  if (jr == LastIdx) begin
                  state_d = (col_q == CW'(NUM_COLUMNS - 1)) ? S_OUT : S_LRNCHK;
                end else state_d = S_LRNRD;
      S_OUT:    if (out_acc && col_q == CW'(NUM_COLUMNS - 1)) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vig_low_q   <= fac_pkg::VIG_LOW_RST;
      vig_high_q  <= fac_pkg::VIG_HIGH_RST;
      bias_q      <= fac_pkg::BIAS_RST;
      rate_q      <= fac_pkg::RATE_RST;
      elem_cnt_q  <= '0;
      learn_q     <= 1'b0;
      committed_q <= '0;
      col_q       <= '0;
      cell_q      <= '0;
      j_q         <= '0;
      div_wait_q  <= 1'b0;
      k_q         <= '0;
      sel_q       <= '0;
      work_zero_q <= '0;
      has_q       <= '0;
      sel_found_q <= 1'b0;
      sel_best_q  <= '0;
      sel_col_q   <= '0;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        comp_q[c]  <= '0;
        shown_q[c] <= '0;
        lcell_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          fac_pkg::REG_VIG_LOW:  vig_low_q  <= cfg_data_i;
          fac_pkg::REG_VIG_HIGH: vig_high_q <= cfg_data_i;
          fac_pkg::REG_BIAS:     bias_q     <= cfg_data_i;
          fac_pkg::REG_RATE:     rate_q     <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && operation_i == fac_pkg::OP_SAMPLE) begin
            if (last_element_i) begin
              elem_cnt_q <= '0;
              learn_q    <= learn_enable_i;
              col_q      <= '0;
              cell_q     <= '0;
              j_q        <= '0;
              sel_q      <= '0;
            end else if (elem_cnt_q < NInp) begin
              elem_cnt_q <= elem_cnt_q + 1'b1;
            end
          end
        end
        S_SUM: begin
          j_q <= (j_q == NInp + 1'b1) ? '0 : j_q + 1'b1;
          div_wait_q <= 1'b1;
        end
        S_DIVM: div_wait_q <= !div_wait_q && !div_busy;
        S_DIVA: div_wait_q <= 1'b0;
        S_CMP: begin
          if (cell_q == DW'(CELLS_PER_COLUMN - 1)) cell_q <= '0;
          else cell_q <= cell_q + 1'b1;
        end
        S_COLEND: begin
          comp_q[col_q]  <= best_low_q;
          shown_q[col_q] <= found_high_q ? win_high_q : win_all_q;
          lcell_q[col_q] <= found_high_q ? win_high_q : '0;
          has_q[col_q]   <= found_high_q;
          col_q <= (col_q == CW'(NUM_COLUMNS - 1)) ? '0 : col_q + 1'b1;
        end
        S_SELINI: begin
          work_zero_q <= '0;
          k_q         <= '0;
          col_q       <= '0;
          sel_found_q <= 1'b0;
          sel_best_q  <= '0;
        end
        S_SEL: begin
          if (col_q == CW'(NUM_COLUMNS - 1)) begin
            col_q       <= '0;
            sel_found_q <= 1'b0;
            sel_best_q  <= '0;
            if (cur_work > sel_best_q) begin
              work_zero_q[col_q] <= 1'b1;
              sel_q[col_q]       <= 1'b1;
            end else if (sel_found_q) begin
              work_zero_q[sel_col_q] <= 1'b1;
              sel_q[sel_col_q]       <= 1'b1;
            end
            k_q <= k_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
            if (cur_work > sel_best_q) begin
              sel_best_q  <= cur_work;
              sel_col_q   <= col_q;
              sel_found_q <= 1'b1;
            end
          end
        end
        S_LRNCHK: begin
          j_q <= '0;
          if (!(sel_q[col_q] && has_q[col_q]) && col_q != CW'(NUM_COLUMNS - 1))
            col_q <= col_q + 1'b1;
          else if (!(sel_q[col_q] && has_q[col_q])) col_q <= '0;
        end
        S_LRNRD: ;
        S_LRNMUL: ;
        S_LRNWR: begin
          if (jr == LastIdx) begin
            committed_q[lcell_idx] <= 1'b1;
            j_q <= '0;
            col_q <= (col_q == CW'(NUM_COLUMNS - 1)) ? '0 : col_q + 1'b1;
          end else begin
            j_q <= {1'b0, jr + 1'b1} ;
          end
        end
        S_OUT: if (out_acc) col_q <= (col_q == CW'(NUM_COLUMNS - 1)) ? '0 : col_q + 1'b1;
        default: ;
      endcase
    end
  end

  // learn read handshake: the ram read is registered, so lrd_second_q holds
  // S_LRNRD until the read data lands in lw_q/lx_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lrd_second_q <= 1'b0;
    else lrd_second_q <= (state_q == S_LRNRD) && !lrd_second_q;
  end

  // datapath registers
  logic [15:0] mn;
  assign mn = (wm < xm) ? wm : xm;
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_SUM: begin
        if (j_q == '0) begin
          min_sum_q <= '0;
          tin_q     <= '0;
          tw_q      <= '0;
        end else if (j_q <= NInp) begin
          min_sum_q <= min_sum_q + SW'(mn);
          tin_q     <= tin_q + SW'(xm);
          tw_q      <= tw_q + SW'(wm);
        end
        if (cell_q == '0 && j_q == '0) begin
          best_low_q   <= '0;
          best_high_q  <= '0;
          best_all_q   <= '0;
          win_high_q   <= '0;
          win_all_q    <= '0;
          found_high_q <= 1'b0;
        end
      end
      S_DIVM: if (!div_wait_q && !div_busy)
                match_q <= committed_q[eval_idx] ? div_quot[16:0] : 17'h10000;
      S_DIVA: if (!div_wait_q && !div_busy)
                act_q <= (act_den == '0) ? 16'd0 :
                         (div_quot > 48'd65535) ? 16'hFFFF : div_quot[15:0];
      S_CMP: begin
        if (match_q >= {1'b0, vig_low_q} && act_q > best_low_q) best_low_q <= act_q;
        if (match_q >= {1'b0, vig_high_q} && act_q > best_high_q) begin
          best_high_q  <= act_q;
          win_high_q   <= cell_q;
          found_high_q <= 1'b1;
        end
        if (act_q > best_all_q) begin
          best_all_q <= act_q;
          win_all_q  <= cell_q;
        end
      end
      S_LRNRD: if (lrd_second_q) begin
        lw_q <= w_rdata;
        lx_q <= x_rdata;
      end
      S_LRNMUL: prod_q <= mul_res;
      default: ;
    endcase
  end

  // outputs
  assign column_o         = 4'(col_q);
  assign shown_cell_o     = 4'(shown_q[col_q]);
  assign has_learn_cell_o = has_q[col_q];
  assign learn_cell_o     = 4'(lcell_q[col_q]);
  assign column_learned_o = sel_q[col_q];
  assign comparison_o     = comp_q[col_q];
  assign last_result_o    = (col_q == CW'(NUM_COLUMNS - 1));
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int NIN     = 64;
  localparam int NCOL    = 16;
  localparam int NCPC    = 16;
  localparam int NCELL   = NCOL * NCPC;
  localparam int NWTS    = NCELL * NIN;
  localparam int EPS     = 7;
  localparam int COMMIT  = 64881;
  // budget for about 16 vectors plus the weight load
  localparam longint CYCLE_LIMIT = 4000000;

  // one result word as seen on the output port
  typedef struct {
    logic [3:0]  column;
    logic [3:0]  shown_cell;
    logic        has_learn_cell;
    logic [3:0]  learn_cell;
    logic        column_learned;
    logic [15:0] comparison;
    logic        last_result;
  } column_word_t;

  // one directed stimulus row
  typedef struct {
    logic        op;
    logic [13:0] addr;
    logic [15:0] value;
    logic        last;
    logic        learn;
  } stim_row_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_we_i         = 1'b0;
  logic [1:0]  cfg_index_i      = '0;
  logic [15:0] cfg_data_i       = '0;
  logic        in_valid_i       = 1'b0;
  logic        operation_i      = 1'b0;
  logic [13:0] weight_address_i = '0;
  logic [15:0] value_i          = '0;
  logic        last_element_i   = 1'b0;
  logic        learn_enable_i   = 1'b0;
  logic        out_stall_i      = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [3:0]  column_o;
  logic [3:0]  shown_cell_o;
  logic        has_learn_cell_o;
  logic [3:0]  learn_cell_o;
  logic        column_learned_o;
  logic [15:0] comparison_o;
  logic        last_result_o;

  fuzzy_art_column_learner dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor copy of the block state
  logic [15:0] vig_low, vig_high, bias, rate;
  logic [15:0] weight_mem [NWTS];
  logic [15:0] input_mem [NIN];
  bit          committed [NCELL];
  int unsigned elem_count;

  column_word_t pending_column_words [$];
  int           fail_count = 0;
  longint       cycle_count = 0;

  // sender burst bookkeeping
  int burst_left = 8;

  // ------------------------------------------------------------------
  // predictor: evaluate every cell, reduce per column, pick learners
  // ------------------------------------------------------------------
  task automatic evaluate_columns(input logic learn);
    longint unsigned mins, tin, tw, den, q, w, x;
    longint unsigned match_v [NCPC];
    longint unsigned act_v [NCPC];
    longint unsigned best_low, best_high, best_all;
    int              win_high, win_all, cell_id, best_col;
    bit              found_high;
    longint unsigned comp [NCOL];
    int              shown [NCOL];
    int              lcell [NCOL];
    bit              has_l [NCOL];
    bit              chosen [NCOL];
    column_word_t    cw;
    for (int c = 0; c < NCOL; c++) begin
      for (int d = 0; d < NCPC; d++) begin
        cell_id = c * NCPC + d;
        mins = 0; tin = 0; tw = 0;
        for (int j = 0; j < NIN; j++) begin
          w = weight_mem[cell_id * NIN + j];
          x = input_mem[j];
          mins += (w < x) ? w : x;
          tin += x;
          tw += w;
        end
        den = (tin > EPS) ? tin : EPS;
        match_v[d] = committed[cell_id] ? ((mins << 16) / den) : 65536;
        den = bias + tw;
        if (den == 0) act_v[d] = 0;
        else begin
          q = (mins << 16) / den;
          act_v[d] = (q > 65535) ? 65535 : q;
        end
      end
      best_low = 0; best_high = 0; best_all = 0;
      win_high = 0; win_all = 0; found_high = 0;
      for (int d = 0; d < NCPC; d++) begin
        if (match_v[d] >= vig_low && act_v[d] > best_low) best_low = act_v[d];
        if (match_v[d] >= vig_high && act_v[d] > best_high) begin
          best_high = act_v[d]; win_high = d; found_high = 1;
        end
        if (act_v[d] > best_all) begin
          best_all = act_v[d]; win_all = d;
        end
      end
      shown[c] = found_high ? win_high : win_all;
      lcell[c] = found_high ? win_high : 0;
      has_l[c] = found_high;
      comp[c]  = best_low;
      chosen[c] = 0;
    end
    // top-1 selection: zero comparison never selected, lowest index on ties
    if (learn) begin
      best_all = 0; best_col = -1;
      for (int c = 0; c < NCOL; c++)
        if (comp[c] > best_all) begin
          best_all = comp[c]; best_col = c;
        end
      if (best_col >= 0) chosen[best_col] = 1;
      for (int c = 0; c < NCOL; c++)
        if (chosen[c] && has_l[c]) begin
          cell_id = c * NCPC + lcell[c];
          for (int j = 0; j < NIN; j++) begin
            w = weight_mem[cell_id * NIN + j];
            x = input_mem[j];
            if (committed[cell_id]) begin
              if (x < w) w = (w * (65536 - rate) + x * rate + 32768) >> 16;
            end else begin
              w = (w * (65536 - COMMIT) + x * COMMIT + 32768) >> 16;
            end
            weight_mem[cell_id * NIN + j] = w[15:0];
          end
          committed[cell_id] = 1;
        end
    end
    for (int c = 0; c < NCOL; c++) begin
      cw.column         = c[3:0];
      cw.shown_cell     = shown[c][3:0];
      cw.has_learn_cell = has_l[c];
      cw.learn_cell     = lcell[c][3:0];
      cw.column_learned = chosen[c];
      cw.comparison     = comp[c][15:0];
      cw.last_result    = (c == NCOL - 1);
      pending_column_words.push_back(cw);
    end
  endtask

  // update predictor for one accepted input word
  task automatic model_accept(input stim_row_t s);
    if (s.op == fac_pkg::OP_WRITE) begin
      weight_mem[s.addr] = s.value;
    end else begin
      if (elem_count < NIN) begin
        input_mem[elem_count] = s.value;
        elem_count++;
      end
      if (s.last) begin
        elem_count = 0;
        evaluate_columns(s.learn);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // sender: called at a rising edge, returns at a rising edge
  // ------------------------------------------------------------------
  task automatic send_word(input stim_row_t s);
    int gap;
    in_valid_i       <= 1'b1;
    operation_i      <= s.op;
    weight_address_i <= s.addr;
    value_i          <= s.value;
    last_element_i   <= s.last;
    learn_enable_i   <= s.learn;
    do @(posedge clk_i); while (in_stall_o);
    model_accept(s);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      // mostly short gaps, now and then a long one, often none
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_weight(input int addr, input int value);
    stim_row_t s;
    s.op = fac_pkg::OP_WRITE; s.addr = addr[13:0]; s.value = value[15:0];
    s.last = 1'($urandom_range(0, 1)); s.learn = 1'($urandom_range(0, 1));
    send_word(s);
  endtask

  // complement-coded vector; len may be short or overlong
  task automatic send_vector(input int len, input logic learn);
    stim_row_t s;
    logic [15:0] half [NIN/2];
    for (int j = 0; j < NIN / 2; j++) half[j] = 16'($urandom_range(0, 65535));
    for (int j = 0; j < len; j++) begin
      s.op    = fac_pkg::OP_SAMPLE;
      s.addr  = 14'($urandom_range(0, NWTS - 1));
      if (j < NIN / 2) s.value = half[j];
      else if (j < NIN) s.value = ~half[j - NIN/2];
      else s.value = 16'($urandom_range(0, 65535));
      s.last  = (j == len - 1);
      s.learn = learn;
      send_word(s);
    end
  endtask

  // wait for every expected word, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_column_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // writes all four registers on consecutive edges; block must be idle
  task automatic set_config(input int lo, input int hi, input int b, input int r);
    logic [15:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{lo[15:0], hi[15:0], b[15:0], r[15:0]};
    idx  = '{fac_pkg::REG_VIG_LOW, fac_pkg::REG_VIG_HIGH,
             fac_pkg::REG_BIAS, fac_pkg::REG_RATE};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    vig_low = lo[15:0]; vig_high = hi[15:0]; bias = b[15:0]; rate = r[15:0];
  endtask

  // ------------------------------------------------------------------
  // receiver stall pattern: one of four modes, redrawn at random on the watchdog's count of cycles
  // ------------------------------------------------------------------
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= cycle_count[2];
    endcase
  end

  // ------------------------------------------------------------------
  // result checker: compare each accepted word with the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    column_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_column_words.size() == 0) begin
        $display("%0t: unexpected result word, column %0d", $realtime, column_o);
        fail_count++;
      end else begin
        e = pending_column_words.pop_front();
        if (column_o !== e.column) begin
          $display("%0t: column exp %0d got %0d", $realtime, e.column, column_o);
          fail_count++;
        end
        if (shown_cell_o !== e.shown_cell) begin
          $display("%0t: shown_cell exp %0d got %0d", $realtime, e.shown_cell, shown_cell_o);
          fail_count++;
        end
        if (has_learn_cell_o !== e.has_learn_cell) begin
          $display("%0t: has_learn_cell exp %0d got %0d", $realtime,
                   e.has_learn_cell, has_learn_cell_o);
          fail_count++;
        end
        if (learn_cell_o !== e.learn_cell) begin
          $display("%0t: learn_cell exp %0d got %0d", $realtime, e.learn_cell, learn_cell_o);
          fail_count++;
        end
        if (column_learned_o !== e.column_learned) begin
          $display("%0t: column_learned exp %0d got %0d", $realtime,
                   e.column_learned, column_learned_o);
          fail_count++;
        end
        if (comparison_o !== e.comparison) begin
          $display("%0t: comparison exp %0d got %0d", $realtime, e.comparison, comparison_o);
          fail_count++;
        end
        if (last_result_o !== e.last_result) begin
          $display("%0t: last_result exp %0d got %0d", $realtime, e.last_result, last_result_o);
          fail_count++;
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fuzzy_art_column_learner test failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  stim_row_t directed [] = '{
    // weight word extremes and alternating address bits
    '{fac_pkg::OP_WRITE,  14'd0,      16'd0,      1'b0, 1'b0},
    '{fac_pkg::OP_WRITE,  14'd16383,  16'd65535,  1'b1, 1'b1},
    '{fac_pkg::OP_WRITE,  14'h2AAA,   16'h5555,   1'b0, 1'b1},
    '{fac_pkg::OP_WRITE,  14'h1555,   16'hAAAA,   1'b1, 1'b0},
    // short vector: one element at full scale, learning on
    '{fac_pkg::OP_SAMPLE, 14'h3FFF,   16'd65535,  1'b1, 1'b1},
    // short vector: one zero element, learning off
    '{fac_pkg::OP_SAMPLE, 14'd0,      16'd0,      1'b1, 1'b0},
    // learn_enable on a non-last word is ignored, last word decides
    '{fac_pkg::OP_SAMPLE, 14'd5,      16'd0,      1'b0, 1'b1},
    '{fac_pkg::OP_SAMPLE, 14'd6,      16'd65535,  1'b1, 1'b0},
    // two elements, learning on
    '{fac_pkg::OP_SAMPLE, 14'd7,      16'd65535,  1'b0, 1'b0},
    '{fac_pkg::OP_SAMPLE, 14'd8,      16'd0,      1'b1, 1'b1}
  };

  initial begin
    int addr;
    vig_low  = fac_pkg::VIG_LOW_RST;
    vig_high = fac_pkg::VIG_HIGH_RST;
    bias     = fac_pkg::BIAS_RST;
    rate     = fac_pkg::RATE_RST;
    elem_count = 0;
    for (int i = 0; i < NCELL; i++) committed[i] = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load every weight before any vector reads the store
    for (int a = 0; a < NWTS; a++) send_weight(a, $urandom_range(0, 65535));
    // first vector must fill the whole input store
    send_vector(NIN, 1'b1);

    foreach (directed[i]) send_word(directed[i]);
    wait_idle();

    // register extremes, each followed by a full vector
    set_config(0, 0, 0, 0);
    send_vector(NIN, 1'b1);
    wait_idle();
    set_config(65535, 65535, 65535, 65535);
    send_vector(NIN, 1'b1);
    wait_idle();
    set_config(fac_pkg::VIG_LOW_RST, fac_pkg::VIG_HIGH_RST,
               fac_pkg::BIAS_RST, fac_pkg::RATE_RST);

    // random part: mostly well-formed vectors, some short or overlong,
    // with stray weight writes
    for (int v = 0; v < 8; v++) begin
      if ($urandom_range(0, 1)) begin
        wait_idle();
        set_config($urandom_range(0, 65535), $urandom_range(20000, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
      repeat ($urandom_range(0, 6)) begin
        addr = $urandom_range(0, NWTS - 1);
        send_weight(addr, $urandom_range(0, 65535));
      end
      case ($urandom_range(0, 5))
        0: send_vector($urandom_range(1, NIN - 1), $urandom_range(0, 3) != 0);
        1: send_vector($urandom_range(NIN + 1, NIN + 6), $urandom_range(0, 3) != 0);
        default: send_vector(NIN, $urandom_range(0, 3) != 0);
      endcase
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("fuzzy_art_column_learner test passed");
    else $display("fuzzy_art_column_learner test failed");
    $finish;
  end

endmodule
